// ===== hdl/spl_pkg.sv =====
package spl_pkg;

	// field widths
	localparam int VAL_W    = 32;
	localparam int CMD_W    = 2;
	localparam int STATUS_W = 2;
	localparam int POS_W    = 4;
	localparam int COUNT_W  = 5;

	// command codes
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

	// control broadcast to every cell of the row
	typedef struct packed {
		logic             ins;
		logic             rem;
		logic [VAL_W-1:0] key;
	} cell_ctl_t;

endpackage

// ===== hdl/spl_cell.sv =====
module spl_cell (
	input  logic                       clk,
	input  spl_pkg::cell_ctl_t         ctl,
	input  logic                       occ,
	input  logic [spl_pkg::VAL_W-1:0]  left_entry,
	input  logic                       left_less,
	input  logic [spl_pkg::VAL_W-1:0]  right_entry,
	output logic [spl_pkg::VAL_W-1:0]  entry,
	output logic                       less,
	output logic                       hit
);

	logic [spl_pkg::VAL_W-1:0] entry_q;

	// local compare against the broadcast key
	assign less  = occ && ($signed(entry_q) < $signed(ctl.key));
	assign hit   = left_less && !less && occ && (entry_q == ctl.key);
	assign entry = entry_q;

	// insert: stay, take the key at the insert point, or shift right
	// remove: take the right neighbor's word
	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (!less) begin
				entry_q <= left_less ? ctl.key : left_entry;
			end
		end else if (ctl.rem) begin
			entry_q <= right_entry;
		end
	end

endmodule

// ===== hdl/sorted_priority_list_core.sv =====
// Sorted priority list: holds up to DEPTH signed 32-bit values in ascending
// order in a row of compare-and-shift cells. cmd 0 inserts value ahead of
// the first stored value that is not smaller (full status when the list is
// full), cmd 1 removes and returns the smallest value (empty status when
// empty), cmd 2 returns the position of the first stored value equal to
// value (not-found status otherwise), cmd 3 does nothing. Every word in
// gives exactly one word out, carrying the count after the operation.
// One operation is accepted per cycle unless in_stall holds the input while
// the output is stalled: all cells compare against the key and shift in the
// same cycle. At the edge that accepts a word the cells update and the
// capture stage takes its command and flag; status and position are then
// encoded into the output register when it loads. position is cut to 4
// bits when DEPTH exceeds 16, entry_count to 5 bits when DEPTH exceeds 31.
module sorted_priority_list_core #(
	parameter int DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [spl_pkg::CMD_W-1:0]            cmd,
	input  logic signed [spl_pkg::VAL_W-1:0]     value,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [spl_pkg::STATUS_W-1:0]         status,
	output logic [spl_pkg::POS_W-1:0]            position,
	output logic signed [spl_pkg::VAL_W-1:0]     removed_value,
	output logic [spl_pkg::COUNT_W-1:0]          entry_count
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [spl_pkg::COUNT_W-1:0] DEPTH_TRUNC = spl_pkg::COUNT_W'(DEPTH);

	logic                          in_acc;
	logic                          full;
	logic                          empty;
	logic [CW-1:0]                 cnt_q;
	logic [CW-1:0]                 cnt_nxt;
	spl_pkg::cell_ctl_t            ctl;

	logic [spl_pkg::VAL_W-1:0]     entry_w [DEPTH];
	logic [DEPTH-1:0]              less_w;
	logic [DEPTH-1:0]              hit_w;
	logic [DEPTH-1:0]              occ_w;

	logic                          s1_vld_q;
	logic [spl_pkg::CMD_W-1:0]     cmd_s1;
	logic                          flag_s1;
	logic [DEPTH-1:0]              hit_s1;
	logic [spl_pkg::VAL_W-1:0]     removed_s1;
	logic [CW-1:0]                 cnt_s1;
	logic [CW+spl_pkg::COUNT_W-1:0] cnt_ext;

	logic                          out_load;
	logic                          out_vld_q;
	logic [spl_pkg::STATUS_W-1:0]  status_q;
	logic [spl_pkg::POS_W-1:0]     pos_q;
	logic [spl_pkg::VAL_W-1:0]     removed_q;
	logic [spl_pkg::COUNT_W-1:0]   count_q;
	logic [spl_pkg::STATUS_W-1:0]  status_nxt;
	logic [spl_pkg::POS_W-1:0]     pos_nxt;

	// handshake between input, capture stage and output register
	assign out_load = s1_vld_q && (!out_vld_q || !out_stall);
	assign in_stall = s1_vld_q && !out_load;
	assign in_acc   = in_valid && !in_stall;

	// command decode against the current count
	assign full  = (cnt_q == DEPTH_C);
	assign empty = (cnt_q == '0);
	assign ctl.ins = in_acc && (cmd == spl_pkg::CMD_INSERT) && !full;
	assign ctl.rem = in_acc && (cmd == spl_pkg::CMD_REMOVE) && !empty;
	assign ctl.key = value;

	always_comb begin
		cnt_nxt = cnt_q;
		if (ctl.ins) begin
			cnt_nxt = cnt_q + CW'(1);
		end else if (ctl.rem) begin
			cnt_nxt = cnt_q - CW'(1);
		end
	end

	// row of cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [spl_pkg::VAL_W-1:0] left_entry;
		logic                      left_less;
		logic [spl_pkg::VAL_W-1:0] right_entry;

		assign occ_w[i] = (cnt_q > CW'(i));

		if (i == 0) begin : g_first
			assign left_entry = ctl.key;
			assign left_less  = 1'b1;
		end else begin : g_mid
			assign left_entry = entry_w[i-1];
			assign left_less  = less_w[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_entry = '0;
		end else begin : g_inner
			assign right_entry = entry_w[i+1];
		end

		spl_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.occ         (occ_w[i]),
			.left_entry  (left_entry),
			.left_less   (left_less),
			.right_entry (right_entry),
			.entry       (entry_w[i]),
			.less        (less_w[i]),
			.hit         (hit_w[i])
		);
	end

	// count and stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			s1_vld_q  <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			cnt_q <= cnt_nxt;
			if (in_acc) begin
				s1_vld_q <= 1'b1;
			end else if (out_load) begin
				s1_vld_q <= 1'b0;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// capture stage: command, full/empty flag, match vector, head word, count
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_s1     <= cmd;
			flag_s1    <= (cmd == spl_pkg::CMD_INSERT) ? full : empty;
			hit_s1     <= (cmd == spl_pkg::CMD_SEARCH) ? hit_w : '0;
			removed_s1 <= ctl.rem ? entry_w[0] : '0;
			cnt_s1     <= cnt_nxt;
		end
	end

	// status and position encode
	always_comb begin
		pos_nxt = '0;
		for (int i = 0; i < DEPTH; i++) begin
			pos_nxt = pos_nxt | (hit_s1[i] ? spl_pkg::POS_W'(i) : '0);
		end
		status_nxt = spl_pkg::ST_OK;
		unique case (cmd_s1)
			spl_pkg::CMD_INSERT: status_nxt = flag_s1 ? spl_pkg::ST_FULL : spl_pkg::ST_OK;
			spl_pkg::CMD_REMOVE: status_nxt = flag_s1 ? spl_pkg::ST_EMPTY : spl_pkg::ST_OK;
			spl_pkg::CMD_SEARCH: status_nxt = (|hit_s1) ? spl_pkg::ST_OK
			                                            : spl_pkg::ST_NOTFOUND;
			spl_pkg::CMD_NOP:    status_nxt = spl_pkg::ST_OK;
			default:             status_nxt = spl_pkg::ST_OK;
		endcase
	end

	assign cnt_ext = {{spl_pkg::COUNT_W{1'b0}}, cnt_s1};

	// output register
	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q  <= status_nxt;
			pos_q     <= pos_nxt;
			removed_q <= removed_s1;
			count_q   <= cnt_ext[spl_pkg::COUNT_W-1:0];
		end
	end

	assign out_valid     = out_vld_q;
	assign status        = status_q;
	assign position      = pos_q;
	assign removed_value = removed_q;
	assign entry_count   = count_q;

	// at most one cell reports the first match
	a_hit_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		s1_vld_q |-> $onehot0(hit_s1))
		else $error("more than one first-match cell");

	// count stays within the row
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DEPTH_C)
		else $error("count beyond depth");

	// an accepted insert into a list with room grows the count by one
	a_ins_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && cmd == spl_pkg::CMD_INSERT && !full) |=> cnt_q == $past(cnt_q) + CW'(1))
		else $error("insert did not grow count");

	// a full refusal reports a full list
	a_full_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && status_q == spl_pkg::ST_FULL) |-> count_q == DEPTH_TRUNC)
		else $error("full status with count below depth");

	// an empty refusal returns nothing and an empty list
	a_empty_out: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && status_q == spl_pkg::ST_EMPTY) |-> (removed_q == '0 && count_q == '0))
		else $error("empty status with data");

endmodule

// ===== sim/tb_top.sv =====
module tb_top;

	localparam int LIST_DEPTH   = 16;
	localparam int RANDOM_WORDS = 1650;
	localparam int PHASE_WORDS  = 50;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int TAIL_CYCLES  = 10;
	localparam int MAX_REPORTS  = 10;

	localparam logic signed [spl_pkg::VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [spl_pkg::VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

	// one output word as the list should produce it
	typedef struct {
		logic [spl_pkg::STATUS_W-1:0]     status;
		logic [spl_pkg::POS_W-1:0]        position;
		logic signed [spl_pkg::VAL_W-1:0] removed;
		logic [spl_pkg::COUNT_W-1:0]      count;
	} list_result_t;

	logic                             clk;
	logic                             arst_n;
	logic                             in_valid;
	logic                             in_stall;
	logic [spl_pkg::CMD_W-1:0]        cmd;
	logic signed [spl_pkg::VAL_W-1:0] value;
	logic                             out_valid;
	logic                             out_stall;
	logic [spl_pkg::STATUS_W-1:0]     status;
	logic [spl_pkg::POS_W-1:0]        position;
	logic signed [spl_pkg::VAL_W-1:0] removed_value;
	logic [spl_pkg::COUNT_W-1:0]      entry_count;

	// shadow copy of the sorted list
	logic signed [spl_pkg::VAL_W-1:0] shadow_list [LIST_DEPTH];
	int                               shadow_len;

	list_result_t pending_results [$];
	int           mismatches;
	int           cycle_count;
	int           stall_left;
	bit           no_idle;

	sorted_priority_list_core #(
		.DEPTH(LIST_DEPTH)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.value        (value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.position     (position),
		.removed_value(removed_value),
		.entry_count  (entry_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// gap lengths: mostly short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 60);
	endfunction

	function automatic int pick_hold();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 50);
	endfunction

	// values: a narrow pool for duplicates, extremes, and the full range
	function automatic logic signed [spl_pkg::VAL_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return $signed($urandom_range(0, 15)) - 8;
		else if (r < 62) begin
			case ($urandom_range(0, 5))
				0: return VAL_MAX;
				1: return VAL_MIN;
				2: return VAL_MAX - 1;
				3: return VAL_MIN + 1;
				4: return -1;
				default: return 0;
			endcase
		end else
			return $urandom;
	endfunction

	// apply one operation to the shadow list and queue its result
	task automatic predict_list_op(input logic [spl_pkg::CMD_W-1:0] op,
			input logic signed [spl_pkg::VAL_W-1:0] v);
		list_result_t r;
		int at;
		int i;
		r.status   = spl_pkg::ST_OK;
		r.position = '0;
		r.removed  = '0;
		case (op)
			spl_pkg::CMD_INSERT: begin
				if (shadow_len >= LIST_DEPTH) begin
					r.status = spl_pkg::ST_FULL;
				end else begin
					at = 0;
					while (at < shadow_len && shadow_list[at] < v)
						at++;
					for (i = shadow_len; i > at; i--)
						shadow_list[i] = shadow_list[i-1];
					shadow_list[at] = v;
					shadow_len++;
				end
			end
			spl_pkg::CMD_REMOVE: begin
				if (shadow_len == 0) begin
					r.status = spl_pkg::ST_EMPTY;
				end else begin
					r.removed = shadow_list[0];
					for (i = 0; i + 1 < shadow_len; i++)
						shadow_list[i] = shadow_list[i+1];
					shadow_len--;
				end
			end
			spl_pkg::CMD_SEARCH: begin
				r.status = spl_pkg::ST_NOTFOUND;
				for (i = 0; i < shadow_len; i++) begin
					if (shadow_list[i] == v) begin
						r.status   = spl_pkg::ST_OK;
						r.position = spl_pkg::POS_W'(i);
						break;
					end
				end
			end
			default: ;
		endcase
		r.count = spl_pkg::COUNT_W'(shadow_len);
		pending_results.push_back(r);
	endtask

	// send one word; called at a rising edge, returns at the edge it is accepted
	task automatic send_word(input logic [spl_pkg::CMD_W-1:0] op,
			input logic signed [spl_pkg::VAL_W-1:0] v);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= op;
		value    <= v;
		// stall is stable from the falling edge to the next rising edge
		forever begin
			@(negedge clk);
			if (!in_stall)
				break;
		end
		@(posedge clk);
		predict_list_op(op, v);
	endtask

	// hold the input idle until every queued result has come back
	task automatic wait_all_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// remove, search and no-op on an empty list
	task automatic test_empty_list();
		send_word(spl_pkg::CMD_REMOVE, VAL_MAX);
		send_word(spl_pkg::CMD_SEARCH, 32'sd0);
		send_word(spl_pkg::CMD_NOP, VAL_MIN);
		send_word(spl_pkg::CMD_REMOVE, 32'sd0);
	endtask

	// extremes of the value range, duplicates, hits and misses
	task automatic test_edge_values();
		send_word(spl_pkg::CMD_INSERT, VAL_MAX);
		send_word(spl_pkg::CMD_INSERT, VAL_MIN);
		send_word(spl_pkg::CMD_INSERT, 32'sd0);
		send_word(spl_pkg::CMD_INSERT, 32'sd0);
		send_word(spl_pkg::CMD_INSERT, -32'sd1);
		send_word(spl_pkg::CMD_SEARCH, 32'sd0);
		send_word(spl_pkg::CMD_SEARCH, VAL_MIN);
		send_word(spl_pkg::CMD_SEARCH, VAL_MAX);
		send_word(spl_pkg::CMD_SEARCH, 32'sd5);
		send_word(spl_pkg::CMD_REMOVE, 32'sd0);
	endtask

	// fill to the top, refuse one more, send a no-op and a search, then let the output drain
	task automatic test_fill_to_full();
		while (shadow_len < LIST_DEPTH)
			send_word(spl_pkg::CMD_INSERT, pick_value());
		send_word(spl_pkg::CMD_INSERT, VAL_MIN);
		send_word(spl_pkg::CMD_NOP, 32'sd0);
		send_word(spl_pkg::CMD_SEARCH, shadow_list[LIST_DEPTH-1]);
		wait_all_results();
	endtask

	// phases biased toward filling, emptying, or neither
	task automatic test_random_mix();
		int n;
		int ph;
		int r;
		logic [spl_pkg::CMD_W-1:0] op;
		logic signed [spl_pkg::VAL_W-1:0] v;
		for (ph = 0; ph * PHASE_WORDS < RANDOM_WORDS; ph++) begin
			no_idle = (ph % 5 == 4);
			if (ph == 16)
				wait_all_results();
			for (n = 0; n < PHASE_WORDS; n++) begin
				r = $urandom_range(0, 99);
				case (ph % 3)
					0: op = (r < 60) ? spl_pkg::CMD_INSERT : (r < 78) ? spl_pkg::CMD_REMOVE :
						(r < 95) ? spl_pkg::CMD_SEARCH : spl_pkg::CMD_NOP;
					1: op = (r < 20) ? spl_pkg::CMD_INSERT : (r < 70) ? spl_pkg::CMD_REMOVE :
						(r < 95) ? spl_pkg::CMD_SEARCH : spl_pkg::CMD_NOP;
					default: op = (r < 38) ? spl_pkg::CMD_INSERT :
						(r < 70) ? spl_pkg::CMD_REMOVE :
						(r < 96) ? spl_pkg::CMD_SEARCH : spl_pkg::CMD_NOP;
				endcase
				// searches mostly look for something that is stored
				if (op == spl_pkg::CMD_SEARCH && shadow_len > 0 &&
						$urandom_range(0, 99) < 60)
					v = shadow_list[$urandom_range(0, shadow_len - 1)];
				else
					v = pick_value();
				send_word(op, v);
			end
		end
		no_idle = 1'b0;
	endtask

	// compare each accepted output word with the oldest expectation
	always @(negedge clk) begin
		list_result_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				if (mismatches < MAX_REPORTS)
					$display("unexpected word: status=%0d position=%0d removed=%0d count=%0d",
						status, position, removed_value, entry_count);
				mismatches++;
			end else begin
				exp_r = pending_results.pop_front();
				if (status !== exp_r.status || position !== exp_r.position ||
						removed_value !== exp_r.removed || entry_count !== exp_r.count) begin
					if (mismatches < MAX_REPORTS)
						$display({"mismatch: exp status=%0d position=%0d removed=%0d ",
							"count=%0d, got status=%0d position=%0d removed=%0d count=%0d"},
							exp_r.status, exp_r.position, exp_r.removed, exp_r.count,
							status, position, removed_value, entry_count);
					mismatches++;
				end
			end
		end
	end

	// output back-pressure
	always @(posedge clk) begin
		if (stall_left != 0) begin
			out_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (!no_idle && $urandom_range(0, 3) == 0) begin
			out_stall  <= 1'b1;
			stall_left <= pick_hold() - 1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		cmd         <= spl_pkg::CMD_NOP;
		value       <= '0;
		out_stall   <= 1'b0;
		stall_left   = 0;
		no_idle      = 1'b0;
		mismatches   = 0;
		cycle_count  = 0;
		shadow_len   = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_edge_values();
		test_fill_to_full();
		test_random_mix();

		wait_all_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
